// ===== src/cht_pkg.sv =====
// shared constants and types for the pawn correction history table
package cht_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16384;
	localparam int unsigned WEIGHT_SCALE      = 256;
	localparam int unsigned GRAIN             = 256;
	localparam int unsigned GRAIN_SH          = $clog2(GRAIN);
	localparam int unsigned MAX_WEIGHT        = 16;

	localparam int unsigned ENTRY_W = 16;
	localparam int unsigned CFG_W   = 15;
	localparam int unsigned KEY_W   = 64;

	localparam logic [CFG_W-1:0] ENTRY_LIMIT_RST = 15'd16384;
	localparam logic [CFG_W-1:0] EVAL_BOUND_RST  = 15'd31743;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_ADJUST = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_ENTRY_LIMIT = 1'b0,
		REG_EVAL_BOUND  = 1'b1
	} cfg_reg_t;

	// clamp limits handed from the register bank to the datapath
	typedef struct packed {
		logic [CFG_W-1:0] entry_limit;
		logic [CFG_W-1:0] eval_bound;
	} cht_limits_t;

endpackage

// ===== src/cht_ram.sv =====
// correction table memory with the clearing sweep after reset
module cht_ram import cht_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic               clr_busy
);

	logic [ENTRY_W-1:0] mem [2*TABLE_ENTRIES];
	logic [ADDR_W-1:0]  clr_idx_q;
	logic               clr_busy_q;

	// one entry per cycle, both banks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == ADDR_W'(2*TABLE_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// ===== src/cht_core.sv =====
// read-modify-write datapath: blend on update, corrected eval on adjust
module cht_core import cht_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES),
	localparam int unsigned ADDR_W = IDX_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cmd_t               in_cmd,
	input  logic               in_side,
	input  logic [KEY_W-1:0]   in_key,
	input  logic [7:0]         in_depth,
	input  logic signed [15:0] in_diff,
	input  logic signed [15:0] in_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_eval,
	input  cht_limits_t        limits,
	input  logic               clr_busy,
	output logic               rd_en,
	output logic [ADDR_W-1:0]  rd_addr,
	input  logic [ENTRY_W-1:0] rd_data,
	output logic               wr_en,
	output logic [ADDR_W-1:0]  wr_addr,
	output logic [ENTRY_W-1:0] wr_data
);

	localparam int unsigned ACC_W = 30;
	localparam int unsigned QUO_W = ACC_W - GRAIN_SH;

	logic               v_s1;
	cmd_t               cmd_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [7:0]         depth_s1;
	logic signed [15:0] diff_s1;
	logic signed [15:0] raw_s1;

	logic                    v_s2;
	logic [ADDR_W-1:0]       addr_s2;
	logic signed [ACC_W-1:0] acc_s2;

	logic               out_v_q;
	logic signed [15:0] out_eval_q;

	logic in_acc;
	logic s1_go;

	logic signed [15:0]      entry;
	logic [4:0]              weight;
	logic [8:0]              keep_w;
	logic signed [24:0]      keep_prod;
	logic signed [20:0]      blend_prod;
	logic signed [ACC_W-1:0] acc_next;

	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [QUO_W-1:0] quo;
	logic signed [QUO_W-1:0] ent_lim;
	logic signed [QUO_W-1:0] ent_new;

	logic signed [16:0] ent_rnd;
	logic signed [16:0] corr;
	logic signed [16:0] sum;
	logic signed [16:0] bnd;
	logic signed [16:0] adj;

	// one item in flight at a time, so a read never meets a pending write
	assign in_ready = !clr_busy && !v_s1 && !v_s2;
	assign in_acc   = in_valid && in_ready;
	assign rd_en    = in_acc;
	assign rd_addr  = {in_side, in_key[IDX_W-1:0]};

	assign s1_go = v_s1 && (cmd_s1 == CMD_UPDATE || !out_v_q || out_ready);

	assign entry = $signed(rd_data);

	always_comb begin
		weight     = (depth_s1 >= 8'(MAX_WEIGHT - 1)) ? 5'(MAX_WEIGHT) : 5'(depth_s1 + 8'd1);
		keep_w     = 9'(WEIGHT_SCALE) - {4'd0, weight};
		keep_prod  = entry * $signed({1'b0, keep_w});
		blend_prod = diff_s1 * $signed({1'b0, weight});
		acc_next   = ACC_W'(keep_prod) + (ACC_W'(blend_prod) <<< GRAIN_SH);
	end

	// divide by the scale truncating toward zero, then clamp
	always_comb begin
		acc_rnd = acc_s2 + (acc_s2[ACC_W-1] ? ACC_W'(GRAIN - 1) : ACC_W'(0));
		quo     = acc_rnd[ACC_W-1:GRAIN_SH];
		ent_lim = $signed({{(QUO_W-CFG_W){1'b0}}, limits.entry_limit});
		if (quo > ent_lim) begin
			ent_new = ent_lim;
		end else if (quo < -ent_lim) begin
			ent_new = -ent_lim;
		end else begin
			ent_new = quo;
		end
	end

	always_comb begin
		ent_rnd = 17'(entry) + (entry[15] ? 17'sd255 : 17'sd0);
		corr    = ent_rnd >>> GRAIN_SH;
		sum     = 17'(raw_s1) + corr;
		bnd     = $signed({2'b00, limits.eval_bound});
		if (sum > bnd) begin
			adj = bnd;
		end else if (sum < -bnd) begin
			adj = -bnd;
		end else begin
			adj = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			v_s2 <= s1_go && cmd_s1 == CMD_UPDATE;
			if (s1_go && cmd_s1 == CMD_ADJUST) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= in_cmd;
			addr_s1  <= rd_addr;
			depth_s1 <= in_depth;
			diff_s1  <= in_diff;
			raw_s1   <= in_raw;
		end
		if (s1_go) begin
			addr_s2 <= addr_s1;
			acc_s2  <= acc_next;
		end
		if (s1_go && cmd_s1 == CMD_ADJUST) begin
			out_eval_q <= adj[15:0];
		end
	end

	assign wr_en     = v_s2;
	assign wr_addr   = addr_s2;
	assign wr_data   = ent_new[ENTRY_W-1:0];
	assign out_valid = out_v_q;
	assign out_eval  = out_eval_q;

endmodule

// ===== src/correction_history_table_top.sv =====
// top level of the pawn correction history table
// Usage:
//   s_axis carries one command per beat. tuser bit 0 picks update or adjust,
//   tuser bit 1 the side to move (table bank). tdata holds pawn_key, depth,
//   eval_diff and raw_eval; the low key bits select the entry.
//   An update blends eval_diff into the entry and yields no beat on m_axis.
//   An adjust yields one beat on m_axis with the corrected evaluation.
//   cfg_we/cfg_addr/cfg_wdata write entry_limit (0) and eval_bound (1); the
//   user must write only while the block is idle, which it does not enforce.
// Flow:
//   m_axis_tvalid rises once an adjust has passed the read stage into the
//   output register; an update writes back from the accumulator register.
//   One item is in flight at a time: the interlock that keeps each table
//   read-modify-write to a single item holds off a new command until the
//   last one is through.
// Reset:
//   the table is swept to zero, one entry per cycle, all 2*TABLE_ENTRIES
//   entries (32768 at the default size); s_axis_tready stays low meanwhile.
// Stall:
//   m_axis holds its beat in an output register; a new item can still be
//   taken while it waits, and an adjust stops at the read stage until the
//   register frees up. TABLE_ENTRIES must be a power of two.
module correction_history_table_top import cht_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES) + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [103:0]     s_axis_tdata,  // pawn_key[63:0], depth, eval_diff, raw_eval
	input  logic [1:0]       s_axis_tuser,  // cmd, side
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // corrected_eval
	input  logic             cfg_we,
	input  cfg_reg_t         cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cht_limits_t limits_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               clr_busy;
	logic signed [15:0] out_eval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.entry_limit <= ENTRY_LIMIT_RST;
			limits_q.eval_bound  <= EVAL_BOUND_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENTRY_LIMIT: limits_q.entry_limit <= cfg_wdata;
				REG_EVAL_BOUND:  limits_q.eval_bound  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cht_ram #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clr_busy(clr_busy)
	);

	cht_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (cmd_t'(s_axis_tuser[0])),
		.in_side  (s_axis_tuser[1]),
		.in_key   (s_axis_tdata[63:0]),
		.in_depth (s_axis_tdata[71:64]),
		.in_diff  ($signed(s_axis_tdata[87:72])),
		.in_raw   ($signed(s_axis_tdata[103:88])),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_eval (out_eval),
		.limits   (limits_q),
		.clr_busy (clr_busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	assign m_axis_tdata = out_eval;

endmodule

// ===== src/cht_chk.sv =====
// port-level checks for the correction history table, bound to the top level
module cht_chk import cht_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed under stall");

	// one item in flight: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// an update never produces a result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_UPDATE && !m_axis_tvalid
		|=> !m_axis_tvalid ##1 !m_axis_tvalid)
		else $error("update produced a result beat");

	// an adjust into an empty output shows up once it has passed the read stage into the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_ADJUST && !m_axis_tvalid
		|=> ##1 m_axis_tvalid)
		else $error("adjust result missing");

	// clamped result never reaches the most negative code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != 16'h8000)
		else $error("corrected eval out of clamp range");

endmodule

bind correction_history_table_top cht_chk u_cht_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
